### sv/text_mode_console_writer_assert.svh
// Assertion macros shared by the console writer modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmcw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmcw assertion failed");

`endif

### sv/tmcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies.
package tmcw_pkg;

  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int CELL_ADDR_W = 11;
  localparam int DATA_W      = 16;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int IDX_W       = 11;
  localparam int ATTR_W      = 8;
  localparam int TAB_STEP    = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'hF0;
  localparam logic [DATA_W-1:0] BLANK_RESET = 16'hF020;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [IDX_W-1:0]  cursor_index;
  } result_t;

endpackage

### sv/tmcw_in_if.sv
// Input word channel of the console writer: valid/ready plus request fields.
// Depends on tmcw_pkg.
interface tmcw_in_if;
  import tmcw_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [CHAR_W-1:0]      char_code;
  logic [CELL_ADDR_W-1:0] cell_address;

  modport source (output valid, action, char_code, cell_address, input ready);
  modport sink   (input valid, action, char_code, cell_address, output ready);
endinterface

### sv/tmcw_out_if.sv
// Result word channel of the console writer: valid/ready plus result fields.
// Depends on tmcw_pkg.
interface tmcw_out_if;
  import tmcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [IDX_W-1:0]  cursor_index;

  modport source (output valid, read_data, cursor_column, cursor_row, cursor_index,
                  input ready);
  modport sink   (input valid, read_data, cursor_column, cursor_row, cursor_index,
                  output ready);
endinterface

### sv/tmcw_cell_mem.sv
// Screen cell memory: one write port, one read port, registered read data.
// Depends on tmcw_pkg.
module tmcw_cell_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tmcw_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [tmcw_pkg::DATA_W-1:0] rd_data
);
  import tmcw_pkg::*;

  logic [DATA_W-1:0] cell_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cell_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/tmcw_seq.sv
// Console sequencer: cursor, attribute, put/clear/read handling and the
// scroll copy and fill sweeps over the cell memory. Depends on tmcw_pkg.
`include "text_mode_console_writer_assert.svh"

module tmcw_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  tmcw_pkg::action_t              action,
  input  logic [tmcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tmcw_pkg::CELL_ADDR_W-1:0] cell_address,
  input  logic                           cfg_we,
  input  logic [tmcw_pkg::ATTR_W-1:0]    cfg_wdata,
  output logic                           idle,
  output logic                           push,
  output tmcw_pkg::result_t              push_res,
  output logic                           mem_wr_en,
  output logic [AW-1:0]                  mem_wr_addr,
  output logic [tmcw_pkg::DATA_W-1:0]    mem_wr_data,
  output logic                           mem_rd_en,
  output logic [AW-1:0]                  mem_rd_addr,
  input  logic [tmcw_pkg::DATA_W-1:0]    mem_rd_data
);
  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS + TAB_STEP);
  localparam int RW    = $clog2(ROWS + 1);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_READ = 5'b00100,
    S_COPY = 5'b01000,
    S_FILL = 5'b10000
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              copy_wr_r, copy_wr_nxt;
  logic [AW-1:0]     copy_dst_r, copy_dst_nxt;
  logic              addr_ok_r, addr_ok_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;

  logic [CW-1:0]     put_col;
  logic [RW-1:0]     put_row;
  logic              put_wr;
  logic              put_scroll;
  logic [AW-1:0]     cur_idx;
  logic              fill_step;
  logic              cnt_last;

  function automatic result_t make_res(input logic [DATA_W-1:0] data,
                                       input logic [CW-1:0] col,
                                       input logic [RW-1:0] row);
    result_t       r;
    logic [AW-1:0] idx;
    idx             = AW'(row) * AW'(COLUMNS) + AW'(col);
    r.read_data     = data;
    r.cursor_column = COL_W'(col);
    r.cursor_row    = ROW_W'(row);
    r.cursor_index  = IDX_W'(idx);
    return r;
  endfunction

  // cursor motion of one put word
  always_comb begin
    put_col = col_r;
    put_row = row_r;
    put_wr  = 1'b0;
    if (char_code == CH_BS) begin
      if (col_r != '0) begin
        put_col = col_r - 1'b1;
      end
    end else if (char_code == CH_TAB) begin
      if (col_r + CW'(TAB_STEP) <= CW'(COLUMNS)) begin
        put_col = col_r + CW'(TAB_STEP);
      end
    end else if (char_code == CH_CR) begin
      put_col = '0;
    end else if (char_code == CH_LF) begin
      put_col = '0;
      put_row = row_r + 1'b1;
    end else if (char_code >= CH_SPACE) begin
      put_wr  = 1'b1;
      put_col = col_r + 1'b1;
    end
    if (put_col >= CW'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    put_scroll = (put_row >= RW'(ROWS));
    if (put_scroll) begin
      put_row = RW'(ROWS - 1);
    end
  end

  assign cur_idx   = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign fill_step = !copy_wr_r;
  assign cnt_last  = (cnt_r == AW'(CELLS - 1));
  assign idle      = (state_r == S_IDLE);

  // memory port drive
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = cnt_r;
    mem_wr_data = {attr_r, CH_SPACE};
    mem_rd_en   = 1'b0;
    mem_rd_addr = cnt_r;
    case (state_r)
      S_INIT: begin
        mem_wr_en   = fill_step;
        mem_wr_data = BLANK_RESET;
      end
      S_IDLE: begin
        if (start && action == ACT_PUT && put_wr) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cur_idx;
          mem_wr_data = {attr_r, char_code};
        end
        if (start && action == ACT_READ) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(cell_address);
        end
      end
      S_COPY: begin
        mem_rd_en = 1'b1;
      end
      S_FILL: begin
        mem_wr_en = fill_step;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
    if (copy_wr_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = copy_dst_r;
      mem_wr_data = mem_rd_data;
    end
  end

  // sequencing and cursor update
  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    cnt_nxt      = cnt_r;
    copy_wr_nxt  = 1'b0;
    copy_dst_nxt = copy_dst_r;
    addr_ok_nxt  = addr_ok_r;
    attr_nxt     = cfg_we ? cfg_wdata : attr_r;
    push         = 1'b0;
    push_res     = make_res('0, col_r, row_r);
    case (state_r)
      S_INIT: begin
        if (fill_step) begin
          if (cnt_last) begin
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_PUT: begin
              col_nxt = put_col;
              row_nxt = put_row;
              if (put_scroll) begin
                state_nxt = S_COPY;
                cnt_nxt   = AW'(COLUMNS);
              end else begin
                push     = 1'b1;
                push_res = make_res('0, put_col, put_row);
              end
            end
            ACT_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_FILL;
            end
            ACT_READ: begin
              addr_ok_nxt = (32'(cell_address) < CELLS);
              state_nxt   = S_READ;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        push      = 1'b1;
        push_res  = make_res(addr_ok_r ? mem_rd_data : '0, col_r, row_r);
        state_nxt = S_IDLE;
      end
      S_COPY: begin
        copy_wr_nxt  = 1'b1;
        copy_dst_nxt = cnt_r - AW'(COLUMNS);
        if (cnt_last) begin
          state_nxt = S_FILL;
          cnt_nxt   = AW'((ROWS - 1) * COLUMNS);
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FILL: begin
        if (fill_step) begin
          if (cnt_last) begin
            push      = 1'b1;
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      col_r     <= '0;
      row_r     <= '0;
      cnt_r     <= '0;
      copy_wr_r <= 1'b0;
      attr_r    <= ATTR_RESET;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      cnt_r     <= cnt_nxt;
      copy_wr_r <= copy_wr_nxt;
      attr_r    <= attr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_dst_r <= copy_dst_nxt;
    addr_ok_r  <= addr_ok_nxt;
  end

  `TMCW_ASSERT_IMP(a_start_idle, clk, rst_n, start, state_r == S_IDLE)
  `TMCW_ASSERT_IMP(a_cursor_range, clk, rst_n, 1'b1, (col_r < CW'(COLUMNS)) && (row_r < RW'(ROWS)))
  `TMCW_ASSERT_NXT(a_clear_fill, clk, rst_n, start && action == ACT_CLEAR, state_r == S_FILL && cnt_r == '0)
  `TMCW_ASSERT_IMP(a_copy_lag, clk, rst_n, copy_wr_r, state_r == S_COPY || state_r == S_FILL)

endmodule

### sv/tmcw_out_q.sv
// Result output register with one skid entry behind it.
// Depends on tmcw_pkg.
`include "text_mode_console_writer_assert.svh"

module tmcw_out_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tmcw_pkg::result_t push_res,
  input  logic              out_ready,
  output logic              out_valid,
  output tmcw_pkg::result_t out_res,
  output logic              full
);
  import tmcw_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_res_r, out_res_nxt;
  result_t skid_res_r, skid_res_nxt;
  logic    pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = push_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = push_res;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign full      = skid_valid_r;

  `TMCW_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `TMCW_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !skid_valid_r)

endmodule

### sv/text_mode_console_writer.sv
// Text console writer top: COLUMNS x ROWS cell memory, cursor sequencer,
// result queue. Depends on tmcw_pkg, tmcw_in_if, tmcw_out_if, tmcw_cell_mem,
// tmcw_seq, tmcw_out_q.
//
//   channel   dir  handshake        payload
//   in_port   in   valid / ready    action, char_code, cell_address
//   out_port  out  valid / ready    read_data, cursor_column, cursor_row, cursor_index
//   cfg       in   cfg_we           cfg_wdata (text attribute)
//
// Put of a control code or a printable character: result pushed from S_IDLE; read cell:
// result pushed from S_READ, behind the registered read port of the cell memory.
// Scroll: one cell moved per cycle through the memory, then the bottom row filled.
// Clear: one cell written per cycle.
// After reset a clearing pass blanks the memory; in_port is not ready until it
// ends. One result may wait on a stalled out_port while the next word is taken.
module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tmcw_pkg::ATTR_W-1:0] cfg_wdata,
  tmcw_in_if.sink                     in_port,
  tmcw_out_if.source                  out_port
);
  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic              seq_idle;
  logic              start;
  logic              push;
  result_t           push_res;
  result_t           out_res;
  logic              q_full;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [DATA_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;

  assign in_port.ready = seq_idle && !q_full;
  assign start         = in_port.valid && in_port.ready;

  tmcw_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  tmcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .action       (action_t'(in_port.action)),
    .char_code    (in_port.char_code),
    .cell_address (in_port.cell_address),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .idle         (seq_idle),
    .push         (push),
    .push_res     (push_res),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  tmcw_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .out_ready (out_port.ready),
    .out_valid (out_port.valid),
    .out_res   (out_res),
    .full      (q_full)
  );

  assign out_port.read_data     = out_res.read_data;
  assign out_port.cursor_column = out_res.cursor_column;
  assign out_port.cursor_row    = out_res.cursor_row;
  assign out_port.cursor_index  = out_res.cursor_index;

endmodule

### dv/text_mode_console_writer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for text_mode_console_writer: directed table, then random phases
// under several text attributes; directed results checked against their table rows,
// random ones against a cycle-free screen model. Depends on tmcw_pkg, tmcw_in_if, tmcw_out_if and the RTL top.
module text_mode_console_writer_tb;
  import tmcw_pkg::*;

  localparam int COLUMNS          = 80;
  localparam int ROWS             = 25;
  localparam int CELLS            = COLUMNS * ROWS;
  localparam int PHASES           = 6;
  localparam int WORDS_PER_PHASE  = 283;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES     = 2 * CELLS + 16;

  typedef struct packed {
    action_t               act;
    logic [CHAR_W-1:0]     code;
    logic [CELL_ADDR_W-1:0] addr;
  } console_req_t;

  typedef struct packed {
    console_req_t word;
    logic         typed;
    result_t      want;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tmcw_in_if  word_in ();
  tmcw_out_if word_out ();

  text_mode_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_port  (word_in),
    .out_port (word_out)
  );

  logic [DATA_W-1:0] screen_model [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] attr_model;
  int unsigned       scroll_count;
  int unsigned       clear_count;

  result_t     pending_results [$];
  table_row_t  bench_rows [$];
  logic        cur_typed;
  result_t     cur_want;
  result_t     want;
  result_t     got;
  int unsigned mismatches;
  int unsigned words_taken;
  int unsigned results_checked;
  int unsigned stall_cycles;
  int unsigned burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t apply_console_word(input action_t act,
                                                 input logic [CHAR_W-1:0] code,
                                                 input logic [CELL_ADDR_W-1:0] addr);
    result_t r;
    int unsigned i;
    r = '0;
    case (act)
      ACT_PUT: begin
        if (code == CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (code == CH_TAB) begin
          if (cur_col + TAB_STEP <= COLUMNS) cur_col += TAB_STEP;
        end else if (code == CH_CR) begin
          cur_col = 0;
        end else if (code == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (code >= CH_SPACE) begin
          screen_model[cur_row * COLUMNS + cur_col] = {attr_model, code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen_model[i] = {attr_model, CH_SPACE};
          cur_row = ROWS - 1;
          scroll_count++;
        end
      end
      ACT_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = {attr_model, CH_SPACE};
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      ACT_READ: begin
        if (addr < CELLS) r.read_data = screen_model[addr];
      end
      default: begin
      end
    endcase
    r.cursor_column = COL_W'(cur_col);
    r.cursor_row    = ROW_W'(cur_row);
    r.cursor_index  = IDX_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic console_req_t random_word(input int lf_weight);
    console_req_t w;
    int roll;
    int unsigned base;
    int unsigned back;
    w.act  = ACT_PUT;
    w.code = CHAR_W'($urandom_range(0, 255));
    w.addr = CELL_ADDR_W'($urandom_range(0, 2047));
    roll   = $urandom_range(0, 99);
    if (roll < 2) begin
      w.act = ACT_NONE;
    end else if (roll < 3) begin
      w.act = ACT_CLEAR;
    end else if (roll < 28) begin
      w.act = ACT_READ;
      if (roll < 16) begin
        base   = cur_row * COLUMNS + cur_col;
        back   = $urandom_range(0, 2 * COLUMNS);
        w.addr = CELL_ADDR_W'((base > back) ? base - back : base);
      end
    end else if (cur_col >= COLUMNS - TAB_STEP && roll < 40) begin
      w.code = CH_TAB;
    end else if (roll < 28 + lf_weight) begin
      w.code = CH_LF;
    end else if (roll < 36 + lf_weight) begin
      case ($urandom_range(0, 2))
        0:       w.code = CH_BS;
        1:       w.code = CH_TAB;
        default: w.code = CH_CR;
      endcase
    end else if (roll < 39 + lf_weight) begin
      w.code = CHAR_W'($urandom_range(0, 31));
    end else begin
      w.code = CHAR_W'($urandom_range(32, 255));
    end
    return w;
  endfunction

  task automatic add_row(input action_t act, input logic [CHAR_W-1:0] code,
                         input logic [CELL_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                         input int unsigned col, input int unsigned row);
    table_row_t t;
    t.word.act              = act;
    t.word.code             = code;
    t.word.addr             = addr;
    t.typed                 = 1'b1;
    t.want.read_data        = data;
    t.want.cursor_column    = COL_W'(col);
    t.want.cursor_row       = ROW_W'(row);
    t.want.cursor_index     = IDX_W'(row * COLUMNS + col);
    bench_rows.push_back(t);
  endtask

  task automatic drive_word(input console_req_t w, input logic typed, input result_t exp_r);
    int gap;
    word_in.valid        <= 1'b1;
    word_in.action       <= w.act;
    word_in.char_code    <= w.code;
    word_in.cell_address <= w.addr;
    cur_typed            <= typed;
    cur_want             <= exp_r;
    @(posedge clk);
    while (!word_in.ready) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        word_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle_and_set_attr(input logic [ATTR_W-1:0] value);
    @(posedge clk);
    while (pending_results.size() != 0 || !word_in.ready) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    attr_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  // receiver: drive ready on one of four patterns, rechosen at random whenever rx_tick[5:0] is zero
  initial begin
    logic [15:0] rx_tick;
    int rx_mode;
    rx_tick = '0;
    rx_mode = 0;
    word_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick = rx_tick + 16'd1;
      if (rx_tick[5:0] == 6'd0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       word_out.ready <= 1'b1;
        1:       word_out.ready <= (rx_tick[1:0] != 2'd3);
        2:       word_out.ready <= ($urandom_range(0, 1) == 0);
        default: word_out.ready <= (rx_tick[4:3] == 2'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (word_out.valid && word_out.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, got 0x%0h", $time,
                   {word_out.read_data, word_out.cursor_column, word_out.cursor_row,
                    word_out.cursor_index});
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          check_field("read_data", want.read_data, word_out.read_data);
          check_field("cursor_column", DATA_W'(want.cursor_column), DATA_W'(word_out.cursor_column));
          check_field("cursor_row", DATA_W'(want.cursor_row), DATA_W'(word_out.cursor_row));
          check_field("cursor_index", DATA_W'(want.cursor_index), DATA_W'(word_out.cursor_index));
        end
      end
      if (word_in.valid && word_in.ready) begin
        words_taken++;
        got = apply_console_word(action_t'(word_in.action), word_in.char_code,
                                 word_in.cell_address);
        pending_results.push_back(cur_typed ? cur_want : got);
      end
    end
    if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr [PHASES];
    int lf_weight [PHASES];
    int p;
    int n;
    int i;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    word_in.valid        <= 1'b0;
    word_in.action       <= ACT_NONE;
    word_in.char_code    <= '0;
    word_in.cell_address <= '0;
    cur_typed            <= 1'b0;
    cur_want             <= '0;

    for (i = 0; i < CELLS; i++) screen_model[i] = BLANK_RESET;
    attr_model      = ATTR_RESET;
    cur_col         = 0;
    cur_row         = 0;
    scroll_count    = 0;
    clear_count     = 0;
    mismatches      = 0;
    words_taken     = 0;
    results_checked = 0;
    stall_cycles    = 0;
    burst_left      = 0;

    phase_attr = '{8'h00, 8'hFF, 8'h00, 8'h0F, 8'h00, 8'hF0};
    phase_attr[2] = ATTR_W'($urandom_range(0, 255));
    phase_attr[4] = ATTR_W'($urandom_range(0, 255));
    lf_weight  = '{3, 12, 3, 20, 5, 8};

    add_row(ACT_READ,  8'h00,  11'd0,    16'hF020, 0, 0);
    add_row(ACT_READ,  8'hFF,  11'd1999, 16'hF020, 0, 0);
    add_row(ACT_READ,  8'h00,  11'h7FF,  16'h0000, 0, 0);
    add_row(ACT_READ,  8'h00,  11'd2000, 16'h0000, 0, 0);
    add_row(ACT_NONE,  8'hFF,  11'h7FF,  16'h0000, 0, 0);
    add_row(ACT_PUT,   CH_BS,  11'h7FF,  16'h0000, 0, 0);
    add_row(ACT_PUT,   8'h41,  11'd0,    16'h0000, 1, 0);
    add_row(ACT_PUT,   8'hFF,  11'h7FF,  16'h0000, 2, 0);
    add_row(ACT_READ,  8'h00,  11'd0,    16'hF041, 2, 0);
    add_row(ACT_READ,  8'h00,  11'd1,    16'hF0FF, 2, 0);
    add_row(ACT_PUT,   CH_BS,  11'd0,    16'h0000, 1, 0);
    add_row(ACT_PUT,   CH_TAB, 11'd0,    16'h0000, 5, 0);
    add_row(ACT_PUT,   CH_CR,  11'd0,    16'h0000, 0, 0);
    add_row(ACT_PUT,   8'h1F,  11'd0,    16'h0000, 0, 0);
    add_row(ACT_PUT,   8'h00,  11'h7FF,  16'h0000, 0, 0);
    add_row(ACT_PUT,   CH_SPACE, 11'd0,  16'h0000, 1, 0);
    add_row(ACT_PUT,   CH_LF,  11'd0,    16'h0000, 0, 1);
    add_row(ACT_PUT,   8'h7E,  11'd0,    16'h0000, 1, 1);
    add_row(ACT_READ,  8'h00,  11'd80,   16'hF07E, 1, 1);
    add_row(ACT_READ,  8'h00,  11'd0,    16'hF020, 1, 1);
    add_row(ACT_PUT,   8'h0B,  11'd0,    16'h0000, 1, 1);
    add_row(ACT_CLEAR, 8'hFF,  11'h7FF,  16'h0000, 0, 0);
    add_row(ACT_READ,  8'h00,  11'd80,   16'hF020, 0, 0);
    add_row(ACT_READ,  8'h00,  11'd1,    16'hF020, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (bench_rows[k]) drive_word(bench_rows[k].word, bench_rows[k].typed, bench_rows[k].want);
    word_in.valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      settle_and_set_attr(phase_attr[p]);
      for (n = 0; n < WORDS_PER_PHASE; n++) drive_word(random_word(lf_weight[p]), 1'b0, '0);
      word_in.valid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words taken, %0d results checked, %0d mismatches", words_taken,
             results_checked, mismatches);
    $display("%0d scrolls, %0d clears over %0d attribute settings", scroll_count,
             clear_count, PHASES + 1);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
